/* rtl/brl_pkg.sv */
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants of the box region lookup block: field widths,
// stream packing offsets, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

    // table size default
    localparam int MAX_REGIONS_DEF = 64;

    // field widths
    localparam int IDX_W    = 6;
    localparam int COORD_W  = 16;
    localparam int REACH_W  = 15;
    localparam int MARGIN_W = 10;
    localparam int CNT_W    = 7;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCATION_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_REACH  = 1'd1;
    localparam logic [REACH_W-1:0]   DEFAULT_REACH_RESET = 15'd1500;

    // request kinds carried in tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // input tdata packing, lowest field first
    localparam int OFS_IDX    = 0;
    localparam int OFS_CX     = OFS_IDX + IDX_W;
    localparam int OFS_CY     = OFS_CX + COORD_W;
    localparam int OFS_CZ     = OFS_CY + COORD_W;
    localparam int OFS_RX     = OFS_CZ + COORD_W;
    localparam int OFS_RY     = OFS_RX + REACH_W;
    localparam int OFS_RZ     = OFS_RY + REACH_W;
    localparam int OFS_PX     = OFS_RZ + REACH_W;
    localparam int OFS_PY     = OFS_PX + COORD_W;
    localparam int OFS_PZ     = OFS_PY + COORD_W;
    localparam int OFS_MARGIN = OFS_PZ + COORD_W;
    localparam int S_USED_W   = OFS_MARGIN + MARGIN_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((IDX_W + 7) / 8) * 8;

    // one unpacked request
    typedef struct packed {
        logic [IDX_W-1:0]    entry_index;
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [COORD_W-1:0]  center_z;
        logic [REACH_W-1:0]  reach_x;
        logic [REACH_W-1:0]  reach_y;
        logic [REACH_W-1:0]  reach_z;
        logic [COORD_W-1:0]  point_x;
        logic [COORD_W-1:0]  point_y;
        logic [COORD_W-1:0]  point_z;
        logic [MARGIN_W-1:0] margin;
    } t_req;

    // controller to datapath
    typedef struct packed {
        logic wr_en;
        logic q_load;
        logic scan;
        logic res_load;
        logic res_found;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic hit;
        logic last;
    } t_status;

endpackage

`default_nettype wire

/* rtl/brl_ctrl.sv */
// ----------------------------------------------------------------------------
// brl_ctrl
// Sequencer of the lookup: accepts requests, walks the table scan and moves
// the finished result into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_req_valid,
    input  wire                   i_req_type,
    output logic                  o_req_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    input  wire brl_pkg::t_status i_status,
    output brl_pkg::t_cmd         o_cmd
);
    import brl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_type == REQ_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.q_load = 1'b1;
                        if (i_status.cnt_zero) begin
                            o_cmd.res_load = 1'b1;
                            n_state        = ST_DONE;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit) begin
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_found = 1'b1;
                    n_state         = ST_DONE;
                end else if (i_status.last) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/brl_datapath.sv */
// ----------------------------------------------------------------------------
// brl_datapath
// Region table memory, configuration registers, scan address counter, the
// per-entry box test and the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_datapath #(
    parameter int MAX_REGIONS = brl_pkg::MAX_REGIONS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [brl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [brl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire  brl_pkg::t_req               i_req,
    input  wire  brl_pkg::t_cmd               i_cmd,
    output brl_pkg::t_status                  o_status,
    output logic                              o_out_found,
    output logic [brl_pkg::IDX_W-1:0]         o_out_idx
);
    import brl_pkg::*;

    localparam int ADDR_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic [REACH_W-1:0] rx;
        logic [REACH_W-1:0] ry;
        logic [REACH_W-1:0] rz;
    } t_entry;

    // one axis: |p - c| <= reach + margin, exact
    function automatic logic axis_hit(input logic [COORD_W-1:0] p,
                                      input logic [COORD_W-1:0] c,
                                      input logic [COORD_W-1:0] lim);
        logic signed [COORD_W+1:0] d;
        logic signed [COORD_W+1:0] l;
        d = (COORD_W+2)'($signed(p)) - (COORD_W+2)'($signed(c));
        l = $signed({2'b00, lim});
        return (d <= l) && (d >= -l);
    endfunction

    t_entry              r_mem [MAX_REGIONS];
    t_entry              r_rd_data;
    logic [ADDR_W-1:0]   r_rd_idx;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_addr;
    logic [CNT_W-1:0]    r_loc_count;
    logic [REACH_W-1:0]  r_def_reach;
    logic [COORD_W-1:0]  r_px, r_py, r_pz;
    logic [MARGIN_W-1:0] r_margin;
    logic                r_res_found;
    logic [IDX_W-1:0]    r_res_idx;
    logic                r_out_found;
    logic [IDX_W-1:0]    r_out_idx;

    logic [CNT_W-1:0]    scan_cnt;
    logic [CNT_W-1:0]    first_addr;
    logic                wr_ok;
    t_entry              wr_entry;
    logic [REACH_W-1:0]  rx_eff, ry_eff;
    logic [COORD_W-1:0]  lim_x, lim_y, lim_z;
    logic                match;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc_count <= '0;
            r_def_reach <= DEFAULT_REACH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOCATION_COUNT: r_loc_count <= i_cfg_data[CNT_W-1:0];
                CFG_DEFAULT_REACH:  r_def_reach <= i_cfg_data[REACH_W-1:0];
                default:            r_def_reach <= r_def_reach;
            endcase
        end
    end

    // scanned length saturates at the table size
    assign scan_cnt   = (r_loc_count > MAX_CNT) ? MAX_CNT : r_loc_count;
    assign first_addr = scan_cnt - CNT_W'(1);

    // table write, out-of-range slots dropped
    assign wr_ok = i_cmd.wr_en && (32'(i_req.entry_index) < MAX_REGIONS);
    assign wr_entry = '{cx: i_req.center_x, cy: i_req.center_y, cz: i_req.center_z,
                        rx: i_req.reach_x,  ry: i_req.reach_y,  rz: i_req.reach_z};

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[i_req.entry_index[ADDR_W-1:0]] <= wr_entry;
        end
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    // read valid flag and scan address, counting down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
        end
        if (i_cmd.q_load) begin
            r_addr <= first_addr[ADDR_W-1:0];
        end else if (i_cmd.scan && (r_addr != '0)) begin
            r_addr <= r_addr - ADDR_W'(1);
        end
    end

    // query operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_px     <= i_req.point_x;
            r_py     <= i_req.point_y;
            r_pz     <= i_req.point_z;
            r_margin <= i_req.margin;
        end
    end

    // box test on the entry just read
    always_comb begin
        rx_eff = (r_rd_data.rx == '0) ? r_def_reach : r_rd_data.rx;
        ry_eff = (r_rd_data.ry == '0) ? r_def_reach : r_rd_data.ry;
        lim_x  = COORD_W'(rx_eff) + COORD_W'(r_margin);
        lim_y  = COORD_W'(ry_eff) + COORD_W'(r_margin);
        lim_z  = COORD_W'(r_rd_data.rz) + COORD_W'(r_margin);
        match  = axis_hit(r_px, r_rd_data.cx, lim_x)
              && axis_hit(r_py, r_rd_data.cy, lim_y)
              && ((r_rd_data.rz == '0) || axis_hit(r_pz, r_rd_data.cz, lim_z));
    end

    assign o_status.cnt_zero = (scan_cnt == '0);
    assign o_status.hit      = r_rd_vld && match;
    assign o_status.last     = r_rd_vld && (r_rd_idx == '0);

    // result and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_found <= i_cmd.res_found;
            r_res_idx   <= i_cmd.res_found ? IDX_W'(r_rd_idx) : '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
        end
    end

    assign o_out_found = r_out_found;
    assign o_out_idx   = r_out_idx;

endmodule

`default_nettype wire

/* rtl/box_region_lookup.sv */
// ----------------------------------------------------------------------------
// box_region_lookup
// Table of up to MAX_REGIONS boxes; a query returns the highest-index box
// that holds a point, every bound widened by a per-query margin.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries requests: tuser 0 writes one table slot, tuser 1 queries.
//   m_axis carries one result per query, none per write: tuser is the found
//   flag, tdata the matching slot index (0 when nothing matched).
//   the cfg channel writes location_count (index 0) and default_reach
//   (index 1); it is always ready and must be used only while idle.
// timing
//   writes can follow every cycle while no query is in progress.
//   a query scans slots n-1 down to 0, one per cycle through the single read
//   port of the table memory, with n = min(location_count, MAX_REGIONS);
//   it stops at the first hit. the result then passes through the result
//   register into the output register and shows on m_axis; s_axis takes no
//   new request until then and takes the next one in that same cycle.
// reset and stall
//   reset clears the sequencer, empties the output register, sets
//   location_count to 0 and default_reach to 1500; table contents are not
//   cleared. a result held by m_axis_tready low does not stop new requests
//   from being taken; a finished query then waits until the output frees.
// ----------------------------------------------------------------------------
`default_nettype none

module box_region_lookup #(
    parameter int MAX_REGIONS = brl_pkg::MAX_REGIONS_DEF  // 1 to 64
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // entry_index, center_x, center_y, center_z, reach_x, reach_y, reach_z,
    // point_x, point_y, point_z, margin (lowest bit up), zero padded
    input  wire  [brl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // req_type
    input  wire                             s_axis_tuser,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // match_index, zero padded
    output logic [brl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // found
    output logic                            m_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [brl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [brl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import brl_pkg::*;

    t_req             req;
    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] out_idx;

    // unpack request fields
    always_comb begin
        req.entry_index = s_axis_tdata[OFS_IDX    +: IDX_W];
        req.center_x    = s_axis_tdata[OFS_CX     +: COORD_W];
        req.center_y    = s_axis_tdata[OFS_CY     +: COORD_W];
        req.center_z    = s_axis_tdata[OFS_CZ     +: COORD_W];
        req.reach_x     = s_axis_tdata[OFS_RX     +: REACH_W];
        req.reach_y     = s_axis_tdata[OFS_RY     +: REACH_W];
        req.reach_z     = s_axis_tdata[OFS_RZ     +: REACH_W];
        req.point_x     = s_axis_tdata[OFS_PX     +: COORD_W];
        req.point_y     = s_axis_tdata[OFS_PY     +: COORD_W];
        req.point_z     = s_axis_tdata[OFS_PZ     +: COORD_W];
        req.margin      = s_axis_tdata[OFS_MARGIN +: MARGIN_W];
    end

    assign o_cfg_ready = 1'b1;

    brl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    brl_datapath #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_found (m_axis_tuser),
        .o_out_idx   (out_idx)
    );

    // pack result
    assign m_axis_tdata = {{(M_TDATA_W-IDX_W){1'b0}}, out_idx};

endmodule

`default_nettype wire

/* rtl/brl_checker.sv */
// ----------------------------------------------------------------------------
// brl_checker
// Port-level checks of the box region lookup, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire [brl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input wire                             s_axis_tuser,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire [brl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input wire                             m_axis_tuser,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready
);
    import brl_pkg::*;

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a miss reports slot zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss with nonzero index");

    // a write request never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (s_axis_tuser == REQ_WRITE) && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result after write request");

    // a query holds off further requests and its result does not rise right away
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (s_axis_tuser == REQ_QUERY) |=>
            !s_axis_tready && !$rose(m_axis_tvalid))
        else $error("query overlap or early result");

endmodule

bind box_region_lookup brl_checker u_brl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

/* verif/brl_result_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_result_check
// Watches the request, result and register channels of the box region
// lookup block. It keeps its own copy of the region table and of the two
// registers, works out the answer to every query it sees accepted, and
// compares each result leaving m_axis with the oldest answer still owed.
// ----------------------------------------------------------------------------

module brl_result_check #(
    parameter int MAX_REGIONS = brl_pkg::MAX_REGIONS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire  [brl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire                             s_axis_tuser,
    input  wire                             s_axis_tvalid,
    input  wire                             s_axis_tready,
    input  wire  [brl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire                             m_axis_tuser,
    input  wire                             m_axis_tvalid,
    input  wire                             m_axis_tready,
    input  wire                             i_cfg_valid,
    input  wire                             o_cfg_ready,
    input  wire  [brl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [brl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import brl_pkg::*;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } t_hit;

    // region table as plain integers, bounds are computed without wrap
    int box_cx [MAX_REGIONS];
    int box_cy [MAX_REGIONS];
    int box_cz [MAX_REGIONS];
    int box_rx [MAX_REGIONS];
    int box_ry [MAX_REGIONS];
    int box_rz [MAX_REGIONS];

    int   scan_count;
    int   reach_dflt;
    t_hit owed_hits [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        scan_count   = 0;
        reach_dflt   = int'(DEFAULT_REACH_RESET);
    end

    function automatic bit in_span(input int p, c, r, m);
        return (p >= c - r - m) && (p <= c + r + m);
    endfunction

    // highest slot among the scanned ones whose widened box holds the point
    function automatic t_hit find_region(input logic [S_TDATA_W-1:0] d);
        t_hit res;
        int   px, py, pz, mg, n, s, rx, ry;
        px  = int'($signed(d[OFS_PX +: COORD_W]));
        py  = int'($signed(d[OFS_PY +: COORD_W]));
        pz  = int'($signed(d[OFS_PZ +: COORD_W]));
        mg  = int'(d[OFS_MARGIN +: MARGIN_W]);
        n   = (scan_count > MAX_REGIONS) ? MAX_REGIONS : scan_count;
        res = '0;
        for (s = n - 1; s >= 0 && !res.found; s--) begin
            rx = (box_rx[s] != 0) ? box_rx[s] : reach_dflt;
            ry = (box_ry[s] != 0) ? box_ry[s] : reach_dflt;
            if (in_span(px, box_cx[s], rx, mg) && in_span(py, box_cy[s], ry, mg) &&
                (box_rz[s] == 0 || in_span(pz, box_cz[s], box_rz[s], mg))) begin
                res.found = 1'b1;
                res.index = s[IDX_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic note_miss(input string what, input int want_v, input int got_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : watch
        t_hit want;
        int   s;
        if (!i_rst_n) begin
            scan_count = 0;
            reach_dflt = int'(DEFAULT_REACH_RESET);
            owed_hits.delete();
        end else begin
            // results against the oldest owed answer
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_hits.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with no query owed, found %0b index %0d",
                                 $realtime, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = owed_hits.pop_front();
                    if (m_axis_tuser !== want.found)
                        note_miss("found", int'(want.found), int'(m_axis_tuser));
                    if (m_axis_tdata !== M_TDATA_W'(want.index))
                        note_miss("match_index", int'(want.index), int'(m_axis_tdata));
                end
            end

            // register writes
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LOCATION_COUNT)
                    scan_count = int'(i_cfg_data[CNT_W-1:0]);
                else if (i_cfg_index == CFG_DEFAULT_REACH)
                    reach_dflt = int'(i_cfg_data[REACH_W-1:0]);
            end

            // accepted request: table write or query
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == REQ_WRITE) begin
                    s = int'(s_axis_tdata[OFS_IDX +: IDX_W]);
                    if (s < MAX_REGIONS) begin
                        box_cx[s] = int'($signed(s_axis_tdata[OFS_CX +: COORD_W]));
                        box_cy[s] = int'($signed(s_axis_tdata[OFS_CY +: COORD_W]));
                        box_cz[s] = int'($signed(s_axis_tdata[OFS_CZ +: COORD_W]));
                        box_rx[s] = int'(s_axis_tdata[OFS_RX +: REACH_W]);
                        box_ry[s] = int'(s_axis_tdata[OFS_RY +: REACH_W]);
                        box_rz[s] = int'(s_axis_tdata[OFS_RZ +: REACH_W]);
                    end
                end else begin
                    owed_hits.push_back(find_region(s_axis_tdata));
                end
            end
        end
        o_pending = owed_hits.size();
    end

endmodule

/* verif/tb_box_region_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_region_lookup
// Loads the whole region table, runs a short set of hand-picked boxes and
// points (edges, extremes, default and zero reach, count saturation), then
// phases of random writes and queries, most aimed near stored boxes, under
// several register settings, with random idling on both streams and one long
// output hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_box_region_lookup;
    import brl_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = REQ_WRITE;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    wire  [M_TDATA_W-1:0]   m_axis_tdata;
    wire                    m_axis_tuser;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    wire                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = CFG_LOCATION_COUNT;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    int fail_count;
    int pending;

    // idling control
    bit quiet      = 1'b0;
    bit hold_armed = 1'b0;
    bit hold_done  = 1'b0;
    int hold_left  = 0;

    // what the stimulus knows of the table, used to aim queries
    int cur_count = 0;
    int cur_reach = int'(DEFAULT_REACH_RESET);
    int slot_cx [MAX_REGIONS_DEF];
    int slot_cy [MAX_REGIONS_DEF];
    int slot_cz [MAX_REGIONS_DEF];
    int slot_rx [MAX_REGIONS_DEF];
    int slot_ry [MAX_REGIONS_DEF];
    int slot_rz [MAX_REGIONS_DEF];

    box_region_lookup #(
        .MAX_REGIONS (MAX_REGIONS_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    brl_result_check #(
        .MAX_REGIONS (MAX_REGIONS_DEF)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, one long hold-off when armed
    always @(negedge i_clk) begin
        if (hold_armed && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    function automatic int clamp_coord(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int rnd_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        return int'(v);
    endfunction

    // half the centers cluster near the origin so boxes overlap
    function automatic int rnd_center();
        if ($urandom_range(1))
            return rnd_coord();
        return int'($urandom_range(8000)) - 4000;
    endfunction

    function automatic int rnd_reach();
        case ($urandom_range(3))
            0:       return 0;
            1:       return $urandom_range(1, 200);
            2:       return $urandom_range(1, 3000);
            default: return $urandom_range(32767);
        endcase
    endfunction

    function automatic int rnd_margin();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1023;
            default: return $urandom_range(1023);
        endcase
    endfunction

    // a coordinate anywhere within a widened bound or up to 3 past it
    function automatic int aim(input int c, r, mg);
        int span;
        span = r + mg + 3;
        return clamp_coord(c + int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_req(input int idx, cx, cy, cz, rx, ry, rz,
                                                      px, py, pz, mg);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[OFS_IDX    +: IDX_W]    = idx[IDX_W-1:0];
        d[OFS_CX     +: COORD_W]  = cx[COORD_W-1:0];
        d[OFS_CY     +: COORD_W]  = cy[COORD_W-1:0];
        d[OFS_CZ     +: COORD_W]  = cz[COORD_W-1:0];
        d[OFS_RX     +: REACH_W]  = rx[REACH_W-1:0];
        d[OFS_RY     +: REACH_W]  = ry[REACH_W-1:0];
        d[OFS_RZ     +: REACH_W]  = rz[REACH_W-1:0];
        d[OFS_PX     +: COORD_W]  = px[COORD_W-1:0];
        d[OFS_PY     +: COORD_W]  = py[COORD_W-1:0];
        d[OFS_PZ     +: COORD_W]  = pz[COORD_W-1:0];
        d[OFS_MARGIN +: MARGIN_W] = mg[MARGIN_W-1:0];
        return d;
    endfunction

    // offer one request, starting and ending at a falling edge; valid stays
    // high on return, so back-to-back requests drop it only for random idle gaps
    task automatic send_req(input logic kind, input logic [S_TDATA_W-1:0] data);
        while (!quiet && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // table write; point and margin fields carry noise
    task automatic put_slot(input int idx, cx, cy, cz, rx, ry, rz);
        slot_cx[idx] = cx;
        slot_cy[idx] = cy;
        slot_cz[idx] = cz;
        slot_rx[idx] = rx;
        slot_ry[idx] = ry;
        slot_rz[idx] = rz;
        send_req(REQ_WRITE, pack_req(idx, cx, cy, cz, rx, ry, rz,
                                     rnd_coord(), rnd_coord(), rnd_coord(), $urandom_range(1023)));
    endtask

    // query; slot fields carry noise
    task automatic ask_point(input int px, py, pz, mg);
        send_req(REQ_QUERY, pack_req($urandom_range(63), rnd_coord(), rnd_coord(), rnd_coord(),
                                     $urandom_range(32767), $urandom_range(32767),
                                     $urandom_range(32767), px, py, pz, mg));
    endtask

    // both registers back to back; the count word gets junk above its 7 bits
    task automatic write_settings(input int count, input int reach);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LOCATION_COUNT;
        i_cfg_data  <= CFG_DATA_W'(($urandom_range(255) << CNT_W) | count);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= CFG_DEFAULT_REACH;
        i_cfg_data  <= reach[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_count = count;
        cur_reach = reach;
    endtask

    // drain all owed results, then leave room for a write still in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // one random request: mostly queries, most of them aimed at a stored box
    task automatic random_item();
        int s, rx, ry, mg;
        if ($urandom_range(99) < 30) begin
            put_slot($urandom_range(MAX_REGIONS_DEF - 1), rnd_center(), rnd_center(),
                     rnd_center(), rnd_reach(), rnd_reach(), rnd_reach());
        end else begin
            mg = rnd_margin();
            if ($urandom_range(99) < 35) begin
                ask_point(rnd_coord(), rnd_coord(), rnd_coord(), mg);
            end else begin
                s = $urandom_range(MAX_REGIONS_DEF - 1);
                if (cur_count > 0 && cur_count < MAX_REGIONS_DEF)
                    s = $urandom_range(cur_count - 1);
                rx = (slot_rx[s] != 0) ? slot_rx[s] : cur_reach;
                ry = (slot_ry[s] != 0) ? slot_ry[s] : cur_reach;
                ask_point(aim(slot_cx[s], rx, mg), aim(slot_cy[s], ry, mg),
                          (slot_rz[s] != 0) ? aim(slot_cz[s], slot_rz[s], mg) : rnd_coord(),
                          mg);
            end
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int i, ph;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // nothing scanned right after reset
        ask_point(0, 0, 0, 1023);

        // load every slot so any count scans written entries only
        for (i = 0; i < MAX_REGIONS_DEF; i++)
            put_slot(i, rnd_center(), rnd_center(), rnd_center(),
                     rnd_reach(), rnd_reach(), rnd_reach());
        settle();
        write_settings(4, int'(DEFAULT_REACH_RESET));

        // default reach with no z test, full-range box, tiny corner box, edges
        put_slot(0, 0, 0, 0, 0, 0, 0);
        put_slot(1, 32767, 32767, 32767, 32767, 32767, 32767);
        put_slot(2, -32768, -32768, -32768, 1, 1, 1);
        put_slot(3, 100, -200, 300, 10, 20, 30);
        ask_point(0, 0, -32768, 0);
        ask_point(1501, 0, -5, 0);
        ask_point(1501, 0, -5, 1);
        ask_point(-32768, -32768, -32768, 1023);
        ask_point(110, -180, 330, 0);
        ask_point(111, -180, 330, 0);
        ask_point(111, -180, 330, 1);
        ask_point(90, -220, 270, 0);
        ask_point(32767, 32767, 32767, 1023);

        // zero default reach: only the exact center of slot 0
        settle();
        write_settings(4, 0);
        ask_point(0, 0, -5, 0);
        ask_point(1, 0, -5, 0);

        // count past the table saturates, widest default reach
        settle();
        write_settings(127, 32767);
        ask_point(-32768, 32767, 0, 0);
        ask_point(32767, -32768, -32768, 1023);

        // random phases under different settings
        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0:       write_settings(64, int'(DEFAULT_REACH_RESET));
                1:       write_settings(127, 0);
                2:       write_settings(3, 32767);
                3:       write_settings(1, $urandom_range(32767));
                4:       write_settings($urandom_range(2, 63), int'(DEFAULT_REACH_RESET));
                default: write_settings(0, 32767);
            endcase
            quiet <= (ph == 2);
            if (ph == 3)
                hold_armed <= 1'b1;
            repeat (150) random_item();
        end
        settle();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/brl_pkg.sv
rtl/brl_ctrl.sv
rtl/brl_datapath.sv
rtl/box_region_lookup.sv
rtl/brl_checker.sv
verif/brl_result_check.sv
verif/tb_box_region_lookup.sv
